// ===== design/assert_macros.svh =====
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/at_rlc_pkg.sv =====
package at_rlc_pkg;

    localparam int unsigned LINE_CAPACITY_DEF = 64;
    localparam int unsigned TIMEOUT_W         = 16;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [TIMEOUT_W-1:0] TICKS_MAX     = 16'hFFFF;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned OUT_DW   = 8;

    localparam logic [REQ_W-1:0] REQ_BYTE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WAIT = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PROMPT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OTHER   = 3'd4;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_PROMPT  = 8'h3E;

    localparam int unsigned NUM_PAT   = 4;
    localparam int unsigned PAT_MAX   = 8;
    localparam int unsigned PAT_IDX_W = 3;
    localparam int unsigned ALIVE_W   = NUM_PAT + 1;
    localparam int unsigned PROMPT_BIT = NUM_PAT;

    typedef logic [BYTE_W-1:0] pat_row_t [PAT_MAX];

    // "OK\r", "SEND OK\r", "ERROR\r", "FAIL\r"
    localparam pat_row_t PAT_TEXT [NUM_PAT] = '{
        '{8'h4F, 8'h4B, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h45, 8'h4E, 8'h44, 8'h20, 8'h4F, 8'h4B, 8'h0D},
        '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h00, 8'h00},
        '{8'h46, 8'h41, 8'h49, 8'h4C, 8'h0D, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] PAT_LEN [NUM_PAT] = '{4'd3, 4'd8, 4'd6, 4'd5};
    localparam logic [STATUS_W-1:0] PAT_STATUS [NUM_PAT] = '{ST_OK, ST_OK, ST_ERROR, ST_ERROR};

endpackage

// ===== design/at_response_line_classifier_top.sv =====
// AT response line classifier. Each stream transaction carries one request: a received
// byte, a timer tick or a begin-wait. Bytes build lines that end at newline or at '>' (either
// terminator, not counted); each finished line gives one result classed as ok, error, prompt
// or other, with its length. A tick while waiting counts up and gives a timeout result once
// the count reaches timeout_ticks. One request is taken every clock cycle; the only limit is
// the single output register, which frees up in the cycle its result is taken. A result
// appears in the cycle after the request that causes it.
module at_response_line_classifier_top #(
    parameter int unsigned LINE_CAPACITY = at_rlc_pkg::LINE_CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [at_rlc_pkg::BYTE_W-1:0]         s_tdata,  // rx_byte
    input  logic [at_rlc_pkg::REQ_W-1:0]          s_tuser,  // req_type
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [at_rlc_pkg::OUT_DW-1:0]         m_tdata,  // line_length, zero pad
    output logic [at_rlc_pkg::STATUS_W-1:0]       m_tuser,  // status
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [at_rlc_pkg::TIMEOUT_W-1:0]      cfg_data  // timeout_ticks
);
    import at_rlc_pkg::*;

    localparam int unsigned CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] CNT_LAST = CW'(LINE_CAPACITY - 1);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CW-1:0]        chars_reg, chars_next;
    logic [ALIVE_W-1:0]   alive_reg, alive_next;
    logic                 waiting_reg, waiting_next;
    logic [TIMEOUT_W-1:0] ticks_reg, ticks_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [LEN_W-1:0]     len_reg, len_next;

    logic                 accept;
    logic                 emit;
    logic [CW-1:0]        cnt;
    logic [ALIVE_W-1:0]   alive_cur;
    logic [TIMEOUT_W-1:0] ticks_inc;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = status_reg;
    assign m_tdata   = OUT_DW'(len_reg);

    always_comb
    begin
        chars_next   = chars_reg;
        alive_next   = alive_reg;
        waiting_next = waiting_reg;
        ticks_next   = ticks_reg;
        emit         = 1'b0;
        status_next  = status_reg;
        len_next     = len_reg;

        // full line restarts before the byte is handled
        cnt       = (chars_reg >= CNT_LAST) ? '0 : chars_reg;
        alive_cur = (chars_reg >= CNT_LAST) ? '1 : alive_reg;
        ticks_inc = (ticks_reg != TICKS_MAX) ? ticks_reg + 1'b1 : ticks_reg;

        case (s_tuser)
            REQ_BYTE:
            begin
                if (s_tdata == CH_NEWLINE || s_tdata == CH_PROMPT)
                begin
                    emit        = 1'b1;
                    len_next    = LEN_W'(cnt);
                    status_next = ST_OTHER;
                    if (s_tdata == CH_PROMPT)
                    begin
                        if (cnt == '0 && alive_cur[PROMPT_BIT])
                            status_next = ST_PROMPT;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_PAT; i++)
                        begin
                            if (alive_cur[i] && cnt == CW'(PAT_LEN[i]))
                                status_next = PAT_STATUS[i];
                        end
                    end
                    chars_next = '0;
                    alive_next = '1;
                    if (status_next == ST_OK || status_next == ST_ERROR)
                        waiting_next = 1'b0;
                end
                else
                begin
                    alive_next = alive_cur;
                    for (int i = 0; i < NUM_PAT; i++)
                    begin
                        if (cnt >= CW'(PAT_LEN[i]) ||
                            PAT_TEXT[i][cnt[PAT_IDX_W-1:0]] != s_tdata)
                            alive_next[i] = 1'b0;
                    end
                    alive_next[PROMPT_BIT] = 1'b0;
                    chars_next = cnt + 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (waiting_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_reg)
                    begin
                        waiting_next = 1'b0;
                        emit         = 1'b1;
                        status_next  = ST_TIMEOUT;
                        len_next     = '0;
                    end
                end
            end
            REQ_WAIT:
            begin
                chars_next   = '0;
                alive_next   = '1;
                waiting_next = 1'b1;
                ticks_next   = '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (accept)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_RESET;
            chars_reg     <= '0;
            alive_reg     <= '1;
            waiting_reg   <= 1'b0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
            if (accept)
            begin
                chars_reg   <= chars_next;
                alive_reg   <= alive_next;
                waiting_reg <= waiting_next;
                ticks_reg   <= ticks_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            status_reg <= status_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== design/at_rlc_checker.sv =====
`include "assert_macros.svh"

module at_rlc_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic [at_rlc_pkg::BYTE_W-1:0]         s_tdata,
    input logic [at_rlc_pkg::REQ_W-1:0]          s_tuser,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [at_rlc_pkg::OUT_DW-1:0]         m_tdata,
    input logic [at_rlc_pkg::STATUS_W-1:0]       m_tuser
);
    import at_rlc_pkg::*;

    logic in_xfer;
    logic is_term;

    assign in_xfer = s_tvalid && s_tready;
    assign is_term = s_tuser == REQ_BYTE && (s_tdata == CH_NEWLINE || s_tdata == CH_PROMPT);

    // stalled result holds
    `CHK_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // timeout carries no length
    `CHK_SAME(a_timeout_len, m_tvalid && m_tuser == ST_TIMEOUT, m_tdata == '0)
    // begin-wait gives no result
    `CHK_NEXT(a_wait_silent, in_xfer && s_tuser == REQ_WAIT, !m_tvalid)
    // every line end gives a result
    `CHK_NEXT(a_term_result, in_xfer && is_term, m_tvalid && m_tuser != ST_TIMEOUT)

endmodule

bind at_response_line_classifier_top at_rlc_checker u_at_rlc_checker (.*);
